// ----- rtl/sm4_pkg.sv -----
// SM4 shared types, constants and round functions.
package sm4_pkg;

  localparam int RoundCount = 32;
  localparam int RndW       = $clog2(RoundCount);
  localparam int WordW      = 32;
  localparam int CfgIdxW    = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_WORD0 = 3'd0,
    REG_KEY_WORD1 = 3'd1,
    REG_KEY_WORD2 = 3'd2,
    REG_KEY_WORD3 = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic             action;
    logic [WordW-1:0] block_word0;
    logic [WordW-1:0] block_word1;
    logic [WordW-1:0] block_word2;
    logic [WordW-1:0] block_word3;
    logic             last_block;
  } in_t;

  typedef struct packed {
    logic [WordW-1:0] result_word0;
    logic [WordW-1:0] result_word1;
    logic [WordW-1:0] result_word2;
    logic [WordW-1:0] result_word3;
    logic             last_block_out;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic            load_key;   // seed state with key ^ FK
    logic            load_blk;   // seed state with input block
    logic            key_step;   // one key expansion round
    logic            data_step;  // one cipher round
    logic [RndW-1:0] rnd;        // current round number
  } cmd_t;

  localparam logic [WordW-1:0] FK [4] = '{
    32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
  };

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] x, input int n);
    return (x << n) | (x >> (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] sub_word(input logic [WordW-1:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  // CK[i] byte j = (4*i + j) * 7 mod 256
  function automatic logic [WordW-1:0] ck_value(input logic [RndW-1:0] i);
    logic [WordW-1:0] v;
    v = '0;
    for (int j = 0; j < 4; j++) begin
      v = {v[23:0], 8'(((4 * int'(i)) + j) * 7)};
    end
    return v;
  endfunction

endpackage

// ----- rtl/sm4_block_cipher.sv -----
// SM4 block cipher top level: controller plus round datapath.
// A block transferred while idle runs 32 rounds, one per cycle, on the shared round
//   unit, then its result is shown in the ST_OUT state.
// A new block is taken only while idle; busy stays high until the result cycle ends.
// Reset (rst_n low, synchronous): key words clear to zero, then the round keys of
//   that key are expanded with busy high; any key write does the same.
// Results are strobed on out_valid for one cycle; the receiver cannot stall.
module sm4_block_cipher (
  input  logic                        clk,
  input  logic                        rst_n,
  // command side
  input  logic                        start,
  output logic                        busy,
  input  sm4_pkg::in_t                in_data,
  // result side
  output logic                        out_valid,
  output sm4_pkg::out_t               out_data,
  // key registers
  input  logic                        cfg_we,
  input  logic [sm4_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sm4_pkg::WordW-1:0]   cfg_wdata
);

  sm4_pkg::cmd_t cmd;

  // Controller: one-hot FSM and round counter. A block transfer happens
  // when start is seen while idle; key writes restart expansion.
  sm4_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Datapath: one round per cycle; the same S-box layer serves key
  // expansion (L') and encryption/decryption (L). Decrypt walks the
  // round key memory backwards.
  sm4_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/sm4_ctrl.sv -----
// SM4 controller: sequences key expansion and the 32 cipher rounds.
module sm4_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       cfg_we,
  input  logic [sm4_pkg::CfgIdxW-1:0] cfg_index,
  output sm4_pkg::cmd_t              cmd,
  output logic                       busy,
  output logic                       out_valid
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_KINIT = 5'b00010,
    ST_KEY   = 5'b00100,
    ST_RUN   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [sm4_pkg::RndW-1:0]  rnd_r, rnd_nxt;
  logic                      key_hit;
  logic                      last_rnd;

  assign key_hit = cfg_we && (cfg_index == sm4_pkg::REG_KEY_WORD0 ||
                              cfg_index == sm4_pkg::REG_KEY_WORD1 ||
                              cfg_index == sm4_pkg::REG_KEY_WORD2 ||
                              cfg_index == sm4_pkg::REG_KEY_WORD3);
  assign last_rnd = (rnd_r == sm4_pkg::RndW'(sm4_pkg::RoundCount - 1));

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          rnd_nxt   = '0;
        end
      end
      ST_KINIT: begin
        state_nxt = ST_KEY;
        rnd_nxt   = '0;
      end
      ST_KEY: begin
        rnd_nxt = rnd_r + 1'b1;
        if (last_rnd) state_nxt = ST_IDLE;
      end
      ST_RUN: begin
        rnd_nxt = rnd_r + 1'b1;
        if (last_rnd) state_nxt = ST_OUT;
      end
      ST_OUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_KINIT;
    endcase
    // a key write always restarts the schedule
    if (key_hit) state_nxt = ST_KINIT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_KINIT;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  assign cmd.load_key  = (state_r == ST_KINIT);
  assign cmd.load_blk  = (state_r == ST_IDLE) && start;
  assign cmd.key_step  = (state_r == ST_KEY);
  assign cmd.data_step = (state_r == ST_RUN);
  assign cmd.rnd       = rnd_r;

endmodule

// ----- rtl/sm4_dp.sv -----
// SM4 datapath: key registers, shared round unit and round key memory.
module sm4_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sm4_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [sm4_pkg::WordW-1:0]   cfg_wdata,
  input  sm4_pkg::in_t                in_data,
  input  sm4_pkg::cmd_t               cmd,
  output sm4_pkg::out_t               out_data
);

  localparam logic [sm4_pkg::RndW-1:0] LastRnd = sm4_pkg::RndW'(sm4_pkg::RoundCount - 1);

  logic [sm4_pkg::WordW-1:0] key_r [4];
  logic [sm4_pkg::WordW-1:0] x_r [4];
  logic [sm4_pkg::WordW-1:0] rk_mem [sm4_pkg::RoundCount];
  logic [sm4_pkg::WordW-1:0] rk_q_r;
  logic                      dec_r;
  logic                      last_r;

  logic [sm4_pkg::RndW-1:0]  nxt_rnd;
  logic [sm4_pkg::RndW-1:0]  rd_addr;
  logic [sm4_pkg::WordW-1:0] mix;
  logic [sm4_pkg::WordW-1:0] sb;
  logic [sm4_pkg::WordW-1:0] lin;
  logic [sm4_pkg::WordW-1:0] nx;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sm4_pkg::REG_KEY_WORD0: key_r[0] <= cfg_wdata;
        sm4_pkg::REG_KEY_WORD1: key_r[1] <= cfg_wdata;
        sm4_pkg::REG_KEY_WORD2: key_r[2] <= cfg_wdata;
        sm4_pkg::REG_KEY_WORD3: key_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared round: S-box layer, then L or L' depending on the pass
  always_comb begin
    mix = x_r[1] ^ x_r[2] ^ x_r[3] ^
          (cmd.key_step ? sm4_pkg::ck_value(cmd.rnd) : rk_q_r);
    sb  = sm4_pkg::sub_word(mix);
    if (cmd.key_step) begin
      lin = sb ^ sm4_pkg::rotl32(sb, 13) ^ sm4_pkg::rotl32(sb, 23);
    end else begin
      lin = sb ^ sm4_pkg::rotl32(sb, 2) ^ sm4_pkg::rotl32(sb, 10) ^
            sm4_pkg::rotl32(sb, 18) ^ sm4_pkg::rotl32(sb, 24);
    end
    nx = x_r[0] ^ lin;
  end

  // round key prefetch: address for the round that runs next cycle
  always_comb begin
    nxt_rnd = cmd.rnd + 1'b1;
    if (cmd.load_blk) begin
      rd_addr = in_data.action ? LastRnd : '0;
    end else begin
      rd_addr = dec_r ? (LastRnd - nxt_rnd) : nxt_rnd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_step) rk_mem[cmd.rnd] <= nx;
    rk_q_r <= rk_mem[rd_addr];
  end

  // state words
  always_ff @(posedge clk) begin
    priority if (cmd.load_key) begin
      for (int i = 0; i < 4; i++) x_r[i] <= key_r[i] ^ sm4_pkg::FK[i];
    end else if (cmd.load_blk) begin
      x_r[0] <= in_data.block_word0;
      x_r[1] <= in_data.block_word1;
      x_r[2] <= in_data.block_word2;
      x_r[3] <= in_data.block_word3;
      dec_r  <= in_data.action;
      last_r <= in_data.last_block;
    end else if (cmd.key_step || cmd.data_step) begin
      x_r[0] <= x_r[1];
      x_r[1] <= x_r[2];
      x_r[2] <= x_r[3];
      x_r[3] <= nx;
    end else begin
    end
  end

  assign out_data.result_word0   = x_r[3];
  assign out_data.result_word1   = x_r[2];
  assign out_data.result_word2   = x_r[1];
  assign out_data.result_word3   = x_r[0];
  assign out_data.last_block_out = last_r;

endmodule

// ----- rtl/sm4_chk.sv -----
// SM4 port-level checker and its bind to the top level.
module sm4_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_we
);

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while not busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a block transfer");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_idle_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !cfg_we) |=> !busy)
    else $error("busy held after result transfer");

endmodule

bind sm4_block_cipher sm4_chk u_sm4_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .cfg_we    (cfg_we)
);
